// ===== hdl/aho_corasick_match_counter_macros.svh =====
// assertion macros for the aho-corasick match counter
// used by the top level, needs clk_i and rst_ni in scope
`ifndef AHO_CORASICK_MATCH_COUNTER_MACROS_SVH
`define AHO_CORASICK_MATCH_COUNTER_MACROS_SVH

// property must hold at every clock edge out of reset
`define ACMC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be true
`define ACMC_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== hdl/acmc_pkg.sv =====
// shared types and constants of the aho-corasick match counter
// no dependencies
package acmc_pkg;

  localparam int NODES      = 16384;
  localparam int ALPHABET   = 26;
  localparam int PATTERNS   = 64;
  localparam int COUNT_BITS = 24;

  localparam int NODE_W     = $clog2(NODES);
  localparam int GOTO_DEPTH = NODES * ALPHABET;
  localparam int GADDR_W    = $clog2(GOTO_DEPTH);
  localparam int SYM_W      = 5;
  localparam int IDX_W      = $clog2(ALPHABET);
  localparam int PID_W      = 7;
  localparam int CNT_DEPTH  = PATTERNS + 1;
  localparam int CADDR_W    = $clog2(CNT_DEPTH);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_BUILD  = 2'd1,
    OP_SCAN   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INS_RD,
    ST_INS_WT,
    ST_INS_END,
    ST_ROOT_RD,
    ST_ROOT_WT,
    ST_POP,
    ST_BU,
    ST_BF,
    ST_BRD,
    ST_BRD2,
    ST_BWT,
    ST_S_RD,
    ST_S_WT,
    ST_S_CH,
    ST_S_CW,
    ST_S_INC,
    ST_S_END,
    ST_R_RD,
    ST_R_WT
  } state_e;

endpackage

// ===== hdl/acmc_ram.sv =====
// generic simple dual port ram, one write port and one registered read port
// no dependencies
module acmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/aho_corasick_match_counter.sv =====
// top level of the aho-corasick match counter: sequencer, trie stores, counts
// depends on acmc_pkg, acmc_ram and aho_corasick_match_counter_macros.svh
//
// channel  dir  contents
// s_axis   in   tuser operation, tdata symbol/pattern_id, tlast last
// m_axis   out  tdata result_pattern/match_count, tlast final_result, tuser overflowed
//
// insert reads and updates the goto store per symbol, build visits each trie node in turn (goto memory port)
// scan follows the fail chain from the new state (one read of the node stores a step)
// a report sends one beat per pattern id up to the highest inserted one, pausing while m_axis_tready_i is low
// after reset and after a clear request a sweep over every goto address zeroes the goto, fail, end and count stores
// s_axis_tready_o is high only between requests; a stalled report holds the sequencer
`include "aho_corasick_match_counter_macros.svh"

module aho_corasick_match_counter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // symbol[4:0], pattern_id[11:5], zero fill
  input  logic [1:0]  s_axis_tuser_i,  // operation[1:0]
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // result_pattern[6:0], match_count[30:7], zero fill
  output logic        m_axis_tuser_o,  // overflowed
  output logic        m_axis_tlast_o
);
  import acmc_pkg::*;

  state_e state_q, state_d;
  logic [GADDR_W-1:0]  clr_q, clr_d;
  logic [NODE_W-1:0]   nodes_q, nodes_d, cursor_q, cursor_d;
  logic [PID_W-1:0]    highest_q, highest_d;
  logic                ovf_q, ovf_d, built_q, built_d;
  logic [SYM_W-1:0]    sym_q, sym_d;
  logic [PID_W-1:0]    pid_q, pid_d;
  logic                last_q, last_d;
  logic [IDX_W-1:0]    i_q, i_d;
  logic [NODE_W:0]     head_q, head_d, tail_q, tail_d, steps_q, steps_d;
  logic [NODE_W-1:0]   u_q, u_d, f_q, f_d, c_q, c_d, t_q, t_d, tn_q, tn_d;
  logic [PID_W-1:0]    id_q, id_d, k_q, k_d;
  logic                mv_q, mv_d, mlast_q, mlast_d, movf_q, movf_d;
  logic [PID_W-1:0]    mpat_q, mpat_d;
  logic [COUNT_BITS-1:0] mcnt_q, mcnt_d;

  logic [NODE_W-1:0]   node_sel;
  logic [IDX_W-1:0]    idx_sel;
  logic [GADDR_W-1:0]  gaddr;
  logic                in_acc, out_free, id_ok;

  logic                g_we, f_we, e_we, q_we, c_we;
  logic [GADDR_W-1:0]  g_waddr, g_raddr;
  logic [NODE_W-1:0]   g_wdata, g_rdata;
  logic [NODE_W-1:0]   f_waddr, f_raddr, f_wdata, f_rdata;
  logic [NODE_W-1:0]   e_waddr;
  logic [PID_W-1:0]    e_wdata, e_rdata;
  logic [NODE_W-1:0]   q_wdata, q_rdata;
  logic [CADDR_W-1:0]  c_waddr, c_raddr;
  logic [COUNT_BITS-1:0] c_wdata, c_rdata;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !mv_q || m_axis_tready_i;
  assign id_ok    = (pid_q >= PID_W'(1)) && (pid_q <= PID_W'(PATTERNS));

  // shared row address unit
  always_comb begin
    unique case (state_q)
      ST_ROOT_RD, ST_ROOT_WT: node_sel = '0;
      ST_BRD, ST_BWT:         node_sel = u_q;
      ST_BRD2:                node_sel = f_q;
      default:                node_sel = cursor_q;
    endcase
    unique case (state_q)
      ST_ROOT_RD, ST_ROOT_WT, ST_BRD, ST_BRD2, ST_BWT: idx_sel = i_q;
      default:                                         idx_sel = sym_q[IDX_W-1:0];
    endcase
  end

  assign gaddr = GADDR_W'(node_sel) * GADDR_W'(ALPHABET) + GADDR_W'(idx_sel);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:   if (clr_q == GADDR_W'(GOTO_DEPTH - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          unique case (op_e'(s_axis_tuser_i))
            OP_INSERT: state_d = built_q ? ST_IDLE :
                                 ((s_axis_tdata_i[4:0] < SYM_W'(ALPHABET)) ?
                                  ST_INS_RD : ST_INS_END);
            OP_BUILD:  state_d = built_q ? ST_IDLE : ST_ROOT_RD;
            OP_SCAN:   state_d = (s_axis_tdata_i[4:0] < SYM_W'(ALPHABET)) ?
                                 ST_S_RD : ST_S_END;
            OP_CLEAR:  state_d = ST_CLEAR;
          endcase
        end
      end
      ST_INS_RD:  state_d = ST_INS_WT;
      ST_INS_WT:  state_d = ST_INS_END;
      ST_INS_END: state_d = ST_IDLE;
      ST_ROOT_RD: state_d = ST_ROOT_WT;
      ST_ROOT_WT: state_d = (i_q == IDX_W'(ALPHABET - 1)) ? ST_POP : ST_ROOT_RD;
      ST_POP:     state_d = (head_q < tail_q) ? ST_BU : ST_IDLE;
      ST_BU:      state_d = ST_BF;
      ST_BF:      state_d = ST_BRD;
      ST_BRD:     state_d = ST_BRD2;
      ST_BRD2:    state_d = ST_BWT;
      ST_BWT:     state_d = (i_q == IDX_W'(ALPHABET - 1)) ? ST_POP : ST_BRD;
      ST_S_RD:    state_d = ST_S_WT;
      ST_S_WT:    state_d = ST_S_CH;
      ST_S_CH:    state_d = ((t_q == '0) || (steps_q == (NODE_W+1)'(NODES))) ?
                            ST_S_END : ST_S_CW;
      ST_S_CW:    state_d = ((e_rdata >= PID_W'(1)) && (e_rdata <= PID_W'(PATTERNS))) ?
                            ST_S_INC : ST_S_CH;
      ST_S_INC:   state_d = ST_S_CH;
      ST_S_END:   state_d = (last_q && (highest_q != '0)) ? ST_R_RD : ST_IDLE;
      ST_R_RD:    state_d = ST_R_WT;
      ST_R_WT:    if (out_free) state_d = (k_q == highest_q) ? ST_IDLE : ST_R_RD;
      default:    state_d = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    clr_d = clr_q;  nodes_d = nodes_q;  cursor_d = cursor_q;  highest_d = highest_q;
    ovf_d = ovf_q;  built_d = built_q;  sym_d = sym_q;  pid_d = pid_q;
    last_d = last_q;  i_d = i_q;  head_d = head_q;  tail_d = tail_q;  steps_d = steps_q;
    u_d = u_q;  f_d = f_q;  c_d = c_q;  t_d = t_q;  tn_d = tn_q;  id_d = id_q;  k_d = k_q;
    mv_d = mv_q && !m_axis_tready_i;
    mlast_d = mlast_q;  movf_d = movf_q;  mpat_d = mpat_q;  mcnt_d = mcnt_q;

    g_we = 1'b0;  g_waddr = gaddr;  g_raddr = gaddr;  g_wdata = '0;
    f_we = 1'b0;  f_waddr = c_q;  f_wdata = '0;
    f_raddr = (state_q == ST_BU) ? q_rdata : t_q;
    e_we = 1'b0;  e_waddr = cursor_q;  e_wdata = pid_q;
    q_we = 1'b0;  q_wdata = '0;
    c_we = 1'b0;  c_waddr = id_q[CADDR_W-1:0];  c_wdata = '0;
    c_raddr = (state_q == ST_R_RD || state_q == ST_R_WT) ? k_q[CADDR_W-1:0] :
              e_rdata[CADDR_W-1:0];

    unique case (state_q)
      ST_CLEAR: begin
        g_we = 1'b1;  g_waddr = clr_q;
        f_we = (clr_q < GADDR_W'(NODES));  f_waddr = clr_q[NODE_W-1:0];
        e_we = f_we;  e_waddr = clr_q[NODE_W-1:0];  e_wdata = '0;
        c_we = (clr_q < GADDR_W'(CNT_DEPTH));  c_waddr = clr_q[CADDR_W-1:0];
        clr_d = clr_q + GADDR_W'(1);
      end
      ST_IDLE: begin
        if (in_acc) begin
          sym_d  = s_axis_tdata_i[4:0];
          pid_d  = s_axis_tdata_i[11:5];
          last_d = s_axis_tlast_i;
          unique case (op_e'(s_axis_tuser_i))
            OP_INSERT: ;
            OP_BUILD: begin
              cursor_d = '0;
              built_d = 1'b1;
              i_d = '0;  head_d = '0;  tail_d = '0;
            end
            OP_SCAN: ;
            OP_CLEAR: begin
              clr_d = '0;  nodes_d = '0;  cursor_d = '0;  highest_d = '0;
              ovf_d = 1'b0;  built_d = 1'b0;
            end
          endcase
        end
      end
      ST_INS_RD: ;
      ST_INS_WT: begin
        if (g_rdata == '0) begin
          if (nodes_q == NODE_W'(NODES - 1)) begin
            ovf_d = 1'b1;
          end else begin
            nodes_d = nodes_q + NODE_W'(1);
            g_we = 1'b1;  g_wdata = nodes_q + NODE_W'(1);
            cursor_d = nodes_q + NODE_W'(1);
          end
        end else begin
          cursor_d = g_rdata;
        end
      end
      ST_INS_END: begin
        if (last_q) begin
          if ((cursor_q != '0) && id_ok) begin
            e_we = 1'b1;
            if (pid_q > highest_q) highest_d = pid_q;
          end
          cursor_d = '0;
        end
      end
      ST_ROOT_RD: ;
      ST_ROOT_WT: begin
        if ((g_rdata != '0) && (tail_q < (NODE_W+1)'(NODES))) begin
          q_we = 1'b1;  q_wdata = g_rdata;  tail_d = tail_q + (NODE_W+1)'(1);
        end
        i_d = i_q + IDX_W'(1);
      end
      ST_POP: ;
      ST_BU: begin
        u_d = q_rdata;
        head_d = head_q + (NODE_W+1)'(1);
      end
      ST_BF: begin
        f_d = f_rdata;
        i_d = '0;
      end
      ST_BRD: ;
      ST_BRD2: c_d = g_rdata;
      ST_BWT: begin
        if (c_q != '0) begin
          f_we = 1'b1;  f_wdata = g_rdata;
          if (tail_q < (NODE_W+1)'(NODES)) begin
            q_we = 1'b1;  q_wdata = c_q;  tail_d = tail_q + (NODE_W+1)'(1);
          end
        end else begin
          g_we = 1'b1;  g_wdata = g_rdata;
        end
        i_d = i_q + IDX_W'(1);
      end
      ST_S_RD: ;
      ST_S_WT: begin
        cursor_d = g_rdata;
        t_d = g_rdata;
        steps_d = '0;
      end
      ST_S_CH: ;
      ST_S_CW: begin
        id_d = e_rdata;
        tn_d = f_rdata;
        if (!((e_rdata >= PID_W'(1)) && (e_rdata <= PID_W'(PATTERNS)))) begin
          t_d = f_rdata;
          steps_d = steps_q + (NODE_W+1)'(1);
        end
      end
      ST_S_INC: begin
        if (c_rdata != {COUNT_BITS{1'b1}}) begin
          c_we = 1'b1;  c_wdata = c_rdata + COUNT_BITS'(1);
        end
        t_d = tn_q;
        steps_d = steps_q + (NODE_W+1)'(1);
      end
      ST_S_END: begin
        if (last_q) begin
          cursor_d = '0;
          k_d = PID_W'(1);
        end
      end
      ST_R_RD: ;
      ST_R_WT: begin
        if (out_free) begin
          mv_d = 1'b1;
          mpat_d = k_q;
          mcnt_d = c_rdata;
          mlast_d = (k_q == highest_q);
          movf_d = ovf_q;
          k_d = k_q + PID_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;  clr_q <= '0;  nodes_q <= '0;  cursor_q <= '0;
      highest_q <= '0;  ovf_q <= 1'b0;  built_q <= 1'b0;
      sym_q <= '0;  pid_q <= '0;  last_q <= 1'b0;  i_q <= '0;  head_q <= '0;
      tail_q <= '0;  steps_q <= '0;  u_q <= '0;  f_q <= '0;  c_q <= '0;  t_q <= '0;
      tn_q <= '0;  id_q <= '0;  k_q <= '0;  mv_q <= 1'b0;  mlast_q <= 1'b0;
      movf_q <= 1'b0;  mpat_q <= '0;  mcnt_q <= '0;
    end else begin
      state_q <= state_d;  clr_q <= clr_d;  nodes_q <= nodes_d;  cursor_q <= cursor_d;
      highest_q <= highest_d;  ovf_q <= ovf_d;  built_q <= built_d;
      sym_q <= sym_d;  pid_q <= pid_d;  last_q <= last_d;  i_q <= i_d;  head_q <= head_d;
      tail_q <= tail_d;  steps_q <= steps_d;  u_q <= u_d;  f_q <= f_d;  c_q <= c_d;
      t_q <= t_d;  tn_q <= tn_d;  id_q <= id_d;  k_q <= k_d;  mv_q <= mv_d;
      mlast_q <= mlast_d;  movf_q <= movf_d;  mpat_q <= mpat_d;  mcnt_q <= mcnt_d;
    end
  end

  acmc_ram #(.WIDTH(NODE_W), .DEPTH(GOTO_DEPTH)) u_goto (
    .clk_i, .we_i(g_we), .waddr_i(g_waddr), .wdata_i(g_wdata),
    .raddr_i(g_raddr), .rdata_o(g_rdata)
  );

  acmc_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_fail (
    .clk_i, .we_i(f_we), .waddr_i(f_waddr), .wdata_i(f_wdata),
    .raddr_i(f_raddr), .rdata_o(f_rdata)
  );

  acmc_ram #(.WIDTH(PID_W), .DEPTH(NODES)) u_end (
    .clk_i, .we_i(e_we), .waddr_i(e_waddr), .wdata_i(e_wdata),
    .raddr_i(t_q), .rdata_o(e_rdata)
  );

  acmc_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_queue (
    .clk_i, .we_i(q_we), .waddr_i(tail_q[NODE_W-1:0]), .wdata_i(q_wdata),
    .raddr_i(head_q[NODE_W-1:0]), .rdata_o(q_rdata)
  );

  acmc_ram #(.WIDTH(COUNT_BITS), .DEPTH(CNT_DEPTH)) u_count (
    .clk_i, .we_i(c_we), .waddr_i(c_waddr), .wdata_i(c_wdata),
    .raddr_i(c_raddr), .rdata_o(c_rdata)
  );

  assign m_axis_tvalid_o = mv_q;
  assign m_axis_tdata_o  = {1'b0, mcnt_q, mpat_q};
  assign m_axis_tlast_o  = mlast_q;
  assign m_axis_tuser_o  = movf_q;

  `ACMC_ASSERT(a_cursor_in_trie, cursor_q <= nodes_q, "cursor beyond allocated nodes")
  `ACMC_ASSERT(a_queue_order, head_q <= tail_q, "build queue head passed tail")
  `ACMC_NEVER(a_report_overrun, (state_q == ST_R_WT) && out_free && (k_q > highest_q),
              "report past highest pattern")
  `ACMC_ASSERT(a_insert_grows, (state_q == ST_INS_WT) |=> (nodes_q >= $past(nodes_q)),
               "node count shrank on insert")

endmodule
